// File: design/lrsp_pkg.sv
// ----------------------------------------------------------------------------
// lrsp_pkg
// Types and codes shared by the shift-reduce parser controller, datapath and
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lrsp_pkg;

   localparam logic [2:0] OP_TOKEN       = 3'd0;
   localparam logic [2:0] OP_LOAD_ACTION = 3'd1;
   localparam logic [2:0] OP_LOAD_GOTO   = 3'd2;
   localparam logic [2:0] OP_LOAD_PROD   = 3'd3;
   localparam logic [2:0] OP_BEGIN       = 3'd4;

   localparam logic [2:0] KIND_EMPTY  = 3'd0;
   localparam logic [2:0] KIND_SHIFT  = 3'd1;
   localparam logic [2:0] KIND_REDUCE = 3'd2;
   localparam logic [2:0] KIND_ACCEPT = 3'd3;

   localparam logic [6:0] END_MARK = 7'd36;

   typedef enum logic [3:0] {
      ST_LOADED        = 4'd0,
      ST_SHIFTED       = 4'd1,
      ST_ACCEPT        = 4'd2,
      ST_NO_ACTION     = 4'd3,
      ST_BAD_PROD      = 4'd4,
      ST_NO_GOTO       = 4'd5,
      ST_STACK_EMPTY   = 4'd6,
      ST_END_UNACCEPT  = 4'd7,
      ST_UNKNOWN       = 4'd8,
      ST_OVERFLOW      = 4'd9,
      ST_REDUCE_LIMIT  = 4'd10,
      ST_IGNORED       = 4'd11
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_LOOKUP,
      S_ACT_WAIT,
      S_PROD_WAIT,
      S_STACK_WAIT,
      S_GOTO_WAIT,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] state_number;
      logic [6:0] symbol;
      logic [2:0] action_kind;
      logic [5:0] target;
      logic [4:0] prod_index;
      logic [3:0] rhs_length;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [3:0] status;
      logic [6:0] reductions;
      logic [5:0] stack_top;
      logic [6:0] stack_depth;
   } rsp_type;

   typedef struct packed {
      logic [6:0] left;
      logic [3:0] len;
   } prod_entry_type;

   typedef struct packed {
      logic       clear;
      logic       capture;
      logic       do_load;
      logic       do_begin;
      logic       act_read;
      logic       push_shift;
      logic       prod_read;
      logic       pop;
      logic       load_top;
      logic       goto_read;
      logic       push_goto;
      logic       set_end;
      logic       end_parse;
      logic       set_code;
      status_type code;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [2:0] op;
      logic       phase;
      logic       load_ok;
      logic       sp_zero;
      logic       act_in_range;
      logic [2:0] kind;
      logic       stack_full;
      logic       prod_ok;
      logic       count_max;
      logic       pop_empty;
      logic       goto_in_range;
      logic       goto_valid;
      logic       is_last;
      logic       sym_is_end;
      logic       out_free;
   } sts_type;

endpackage

`default_nettype wire

// File: design/lr_shift_reduce_parser.sv
// ----------------------------------------------------------------------------
// lr_shift_reduce_parser
// Table-driven LR shift-reduce parser with loadable action, goto and
// production tables and one result beat per request beat.
// ----------------------------------------------------------------------------
// After reset the action and goto tables are swept clear, one entry per cycle
// over all min(STATE_COUNT,64) * min(SYMBOL_COUNT,128) entries (8192 by
// default); no request beat is taken until the sweep ends. A load, begin or
// ignored request is accepted, executed and then its result is written into
// the output register. A token makes an action lookup per reduce plus one for
// the final shift, accept or error, counted over both runs when the implicit
// end marker follows: each lookup is one read of the action memory, each
// reduce a read of the production store, a read of the state stack memory and
// a read of the goto memory, all in turn. An error found before a memory read
// ends a token early: an empty stack or an out-of-range lookup skips the
// action read, and a reduce that empties the stack or finds no goto column
// stops without its goto read. A result that cannot enter the output register
// holds the parser until the register is free. A new request is taken while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_shift_reduce_parser
   import lrsp_pkg::*;
#(
   parameter int STATE_COUNT      = 64,
   parameter int SYMBOL_COUNT     = 128,
   parameter int PRODUCTION_COUNT = 32,
   parameter int STACK_DEPTH      = 64,
   parameter int MAX_RHS          = 15,
   parameter int MAX_REDUCES      = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   lrsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrsp_datapath #(
      .STATE_COUNT      (STATE_COUNT),
      .SYMBOL_COUNT     (SYMBOL_COUNT),
      .PRODUCTION_COUNT (PRODUCTION_COUNT),
      .STACK_DEPTH      (STACK_DEPTH),
      .MAX_RHS          (MAX_RHS),
      .MAX_REDUCES      (MAX_REDUCES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// File: design/lrsp_ctrl.sv
// ----------------------------------------------------------------------------
// lrsp_ctrl
// Sequencer of the parser: table clearing, item decode, the reduce loop of a
// token and hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_ctrl
   import lrsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.code  = ST_IGNORED;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_code = 1'b1;
            state_in     = S_DONE;
            unique case (sts.op)
               OP_TOKEN: begin
                  if (sts.phase) begin
                     cmd.set_code = 1'b0;
                     state_in     = S_LOOKUP;
                  end
               end
               OP_LOAD_ACTION, OP_LOAD_GOTO, OP_LOAD_PROD: begin
                  cmd.do_load = 1'b1;
                  cmd.code    = sts.load_ok ? ST_LOADED : ST_IGNORED;
               end
               OP_BEGIN: begin
                  cmd.do_begin = 1'b1;
                  cmd.code     = ST_LOADED;
               end
               default: cmd.code = ST_IGNORED;
            endcase
         end
         S_LOOKUP: begin
            if (sts.sp_zero) begin
               cmd.code = ST_STACK_EMPTY;
            end else if (!sts.act_in_range) begin
               cmd.code = ST_NO_ACTION;
            end else begin
               cmd.act_read = 1'b1;
            end
            if (cmd.act_read) begin
               state_in = S_ACT_WAIT;
            end else begin
               cmd.set_code  = 1'b1;
               cmd.end_parse = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_ACT_WAIT: begin
            cmd.set_code  = 1'b1;
            cmd.end_parse = 1'b1;
            state_in      = S_DONE;
            case (sts.kind)
               KIND_EMPTY:  cmd.code = ST_NO_ACTION;
               KIND_ACCEPT: cmd.code = ST_ACCEPT;
               KIND_SHIFT: begin
                  if (sts.stack_full) begin
                     cmd.code = ST_OVERFLOW;
                  end else begin
                     cmd.push_shift = 1'b1;
                     if (!sts.is_last) begin
                        cmd.code      = ST_SHIFTED;
                        cmd.end_parse = 1'b0;
                     end else if (!sts.sym_is_end) begin
                        cmd.set_end   = 1'b1;
                        cmd.set_code  = 1'b0;
                        cmd.end_parse = 1'b0;
                        state_in      = S_LOOKUP;
                     end else begin
                        cmd.code = ST_END_UNACCEPT;
                     end
                  end
               end
               KIND_REDUCE: begin
                  if (!sts.prod_ok) begin
                     cmd.code = ST_BAD_PROD;
                  end else if (sts.count_max) begin
                     cmd.code = ST_REDUCE_LIMIT;
                  end else begin
                     cmd.prod_read = 1'b1;
                     cmd.set_code  = 1'b0;
                     cmd.end_parse = 1'b0;
                     state_in      = S_PROD_WAIT;
                  end
               end
               default: cmd.code = ST_UNKNOWN;
            endcase
         end
         S_PROD_WAIT: begin
            cmd.pop = 1'b1;
            if (sts.pop_empty) begin
               cmd.code      = ST_STACK_EMPTY;
               cmd.set_code  = 1'b1;
               cmd.end_parse = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_STACK_WAIT;
            end
         end
         S_STACK_WAIT: begin
            cmd.load_top = 1'b1;
            if (!sts.goto_in_range) begin
               cmd.code      = ST_NO_GOTO;
               cmd.set_code  = 1'b1;
               cmd.end_parse = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.goto_read = 1'b1;
               state_in      = S_GOTO_WAIT;
            end
         end
         S_GOTO_WAIT: begin
            if (!sts.goto_valid) begin
               cmd.code = ST_NO_GOTO;
            end else if (sts.stack_full) begin
               cmd.code = ST_OVERFLOW;
            end else begin
               cmd.push_goto = 1'b1;
            end
            if (cmd.push_goto) begin
               state_in = S_LOOKUP;
            end else begin
               cmd.set_code  = 1'b1;
               cmd.end_parse = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

`default_nettype wire

// File: design/lrsp_datapath.sv
// ----------------------------------------------------------------------------
// lrsp_datapath
// Action, goto and production stores, the state stack with its pointer and
// top register, the reduce counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrsp_datapath
   import lrsp_pkg::*;
#(
   parameter int STATE_COUNT      = 64,
   parameter int SYMBOL_COUNT     = 128,
   parameter int PRODUCTION_COUNT = 32,
   parameter int STACK_DEPTH      = 64,
   parameter int MAX_RHS          = 15,
   parameter int MAX_REDUCES      = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire cmd_type cmd,
   output sts_type      sts
);

   localparam int ROWS        = (STATE_COUNT < 64) ? STATE_COUNT : 64;
   localparam int COLS        = (SYMBOL_COUNT < 128) ? SYMBOL_COUNT : 128;
   localparam int TABLE_DEPTH = ROWS * COLS;
   localparam int TAW         = $clog2(TABLE_DEPTH);
   localparam int PROD_SLOTS  = (PRODUCTION_COUNT < 32) ? PRODUCTION_COUNT : 32;
   localparam int PIW         = $clog2(PROD_SLOTS);
   localparam int SPW         = $clog2(STACK_DEPTH + 1);
   localparam int STW         = $clog2(STACK_DEPTH);
   localparam int LW          = (SPW > 4) ? SPW : 4;
   localparam int CW          = $clog2(MAX_REDUCES + 1);

   logic [8:0]     action_mem [TABLE_DEPTH];
   logic [6:0]     goto_mem   [TABLE_DEPTH];
   prod_entry_type prod_mem   [PROD_SLOTS];
   logic [5:0]     stack_mem  [STACK_DEPTH];

   req_type        req_ff;
   logic [6:0]     sym_ff;
   logic [SPW-1:0] sp_ff;
   logic [5:0]     top_ff;
   logic [CW-1:0]  count_ff;
   logic           phase_ff;
   status_type     code_ff;
   logic [TAW-1:0] clr_ff;
   logic [PROD_SLOTS-1:0] prod_valid_ff;
   logic [8:0]     action_rd_ff;
   logic [6:0]     goto_rd_ff;
   prod_entry_type prod_rd_ff;
   logic [5:0]     stack_rd_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;

   logic [TAW-1:0] load_addr;
   logic [TAW-1:0] act_addr;
   logic [TAW-1:0] goto_addr;
   logic           load_in_range;
   logic [3:0]     len_sat;
   logic [LW-1:0]  sp_w;
   logic [LW-1:0]  len_w;
   logic [SPW-1:0] newsp;
   logic [SPW-1:0] rd_idx;
   logic [5:0]     push_val;
   logic           push;

   assign load_addr = TAW'(req_ff.state_number) * TAW'(COLS) + TAW'(req_ff.symbol);
   assign act_addr  = TAW'(top_ff) * TAW'(COLS) + TAW'(sym_ff);
   assign goto_addr = TAW'(stack_rd_ff) * TAW'(COLS) + TAW'(prod_rd_ff.left);
   assign load_in_range = (int'(req_ff.state_number) < ROWS) &&
                          (int'(req_ff.symbol) < COLS);
   assign len_sat = (int'(req_ff.rhs_length) > MAX_RHS) ? 4'(MAX_RHS) : req_ff.rhs_length;

   assign sp_w   = LW'(sp_ff);
   assign len_w  = LW'(prod_rd_ff.len);
   assign newsp  = (len_w >= sp_w) ? '0 : SPW'(sp_w - len_w);
   assign rd_idx = newsp - SPW'(1);

   assign push     = cmd.push_shift | cmd.push_goto;
   assign push_val = cmd.push_goto ? goto_rd_ff[5:0] : action_rd_ff[5:0];

   // table stores, cleared by the sweep after reset
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         action_mem[clr_ff] <= '0;
         goto_mem[clr_ff]   <= '0;
      end else if (cmd.do_load && load_in_range) begin
         if (req_ff.op == OP_LOAD_ACTION) begin
            action_mem[load_addr] <= {req_ff.action_kind, req_ff.target};
         end
         if (req_ff.op == OP_LOAD_GOTO) begin
            goto_mem[load_addr] <= {1'b1, req_ff.target};
         end
      end
      if (cmd.act_read) action_rd_ff <= action_mem[act_addr];
      if (cmd.goto_read) goto_rd_ff <= goto_mem[goto_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.do_load && req_ff.op == OP_LOAD_PROD &&
          int'(req_ff.prod_index) < PROD_SLOTS) begin
         prod_mem[req_ff.prod_index[PIW-1:0]] <= '{left: req_ff.symbol, len: len_sat};
      end
      if (cmd.prod_read) prod_rd_ff <= prod_mem[action_rd_ff[PIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.do_begin) begin
         stack_mem[0] <= '0;
      end else if (push) begin
         stack_mem[sp_ff[STW-1:0]] <= push_val;
      end
      if (cmd.pop) stack_rd_ff <= stack_mem[rd_idx[STW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff         <= '0;
         phase_ff      <= 1'b0;
         clr_ff        <= '0;
         prod_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + TAW'(1);
         if (cmd.do_load && req_ff.op == OP_LOAD_PROD &&
             int'(req_ff.prod_index) < PROD_SLOTS) begin
            prod_valid_ff[req_ff.prod_index[PIW-1:0]] <= 1'b1;
         end
         if (cmd.do_begin) begin
            sp_ff    <= SPW'(1);
            phase_ff <= 1'b1;
         end else if (push) begin
            sp_ff <= sp_ff + SPW'(1);
         end else if (cmd.pop) begin
            sp_ff <= newsp;
         end
         if (cmd.end_parse) phase_ff <= 1'b0;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff   <= req_data;
         sym_ff   <= req_data.symbol;
         count_ff <= '0;
      end
      if (cmd.set_end) sym_ff <= END_MARK;
      if (cmd.prod_read) count_ff <= count_ff + CW'(1);
      if (cmd.do_begin) begin
         top_ff <= '0;
      end else if (push) begin
         top_ff <= push_val;
      end else if (cmd.load_top) begin
         top_ff <= stack_rd_ff;
      end
      if (cmd.set_code) code_ff <= cmd.code;
      if (cmd.emit) begin
         rsp_data_ff.status      <= code_ff;
         rsp_data_ff.reductions  <= 7'(count_ff);
         rsp_data_ff.stack_top   <= (sp_ff == '0) ? 6'd0 : top_ff;
         rsp_data_ff.stack_depth <= 7'(sp_ff);
      end
   end

   always_comb begin
      sts               = '0;
      sts.clear_done    = (clr_ff == TAW'(TABLE_DEPTH - 1));
      sts.op            = req_ff.op;
      sts.phase         = phase_ff;
      sts.load_ok       = (req_ff.op == OP_LOAD_PROD) ? (int'(req_ff.prod_index) < PROD_SLOTS)
                                                       : load_in_range;
      sts.sp_zero       = (sp_ff == '0);
      sts.act_in_range  = (int'(top_ff) < ROWS) && (int'(sym_ff) < COLS);
      sts.kind          = action_rd_ff[8:6];
      sts.stack_full    = (int'(sp_ff) >= STACK_DEPTH);
      sts.prod_ok       = (int'(action_rd_ff[5:0]) < PROD_SLOTS) &&
                          prod_valid_ff[action_rd_ff[PIW-1:0]];
      sts.count_max     = (int'(count_ff) >= MAX_REDUCES);
      sts.pop_empty     = (len_w >= sp_w);
      sts.goto_in_range = (int'(stack_rd_ff) < ROWS) && (int'(prod_rd_ff.left) < COLS);
      sts.goto_valid    = goto_rd_ff[6];
      sts.is_last       = req_ff.is_last;
      sts.sym_is_end    = (sym_ff == END_MARK);
      sts.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
